// ----- design/oaht_pkg.sv -----
`default_nettype none
package oaht_pkg;
	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_BYTES_DEF = 8;
	localparam int KEY_W         = 64;
	localparam int VAL_W         = 32;
	localparam int CNT_W         = 7;
	localparam int CFG_W         = 7;
	localparam int CFG_IDX_W     = 1;

	localparam logic [2:0] ACT_INSERT = 3'd0;
	localparam logic [2:0] ACT_SEARCH = 3'd1;
	localparam logic [2:0] ACT_DELETE = 3'd2;
	localparam logic [2:0] ACT_UPDATE = 3'd3;
	localparam logic [2:0] ACT_CLEAR  = 3'd4;

	localparam logic [2:0] ST_INSERTED    = 3'd0;
	localparam logic [2:0] ST_OVERWRITTEN = 3'd1;
	localparam logic [2:0] ST_FOUND       = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
	localparam logic [2:0] ST_DELETED_RES = 3'd4;
	localparam logic [2:0] ST_FULL        = 3'd5;
	localparam logic [2:0] ST_CLEARED     = 3'd6;

	localparam logic [1:0] SLOT_EMPTY    = 2'd0;
	localparam logic [1:0] SLOT_OCCUPIED = 2'd1;
	localparam logic [1:0] SLOT_DELETED  = 2'd2;

	localparam logic [1:0] PM_LINEAR    = 2'd0;
	localparam logic [1:0] PM_QUADRATIC = 2'd1;

	localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'd1;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;       // latch input item, start hashing
		logic hash_step;  // fold one key byte into both hashes
		logic mod_start;  // begin modular reduction
		logic mod_step;   // one restoring-subtract step
		logic probe_init; // set probe index to the reduced hash
		logic rd;         // read slot at current index
		logic act;        // evaluate read slot, write if needed
		logic next;       // advance probe
		logic clr_step;   // mark one slot empty
		logic clr_start;
		logic fin_full;   // finish with scan exhausted
		logic fin_imm;    // finish for clear/unused action
	} oaht_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic hash_done;
		logic mod_done;
		logic hit_done;   // evaluation ended the scan
		logic scan_last;  // probe count reached capacity
		logic clr_done;
		logic act_clear;
		logic act_bad;
	} oaht_sts_t;
endpackage
`default_nettype wire

// ----- design/oaht_if.sv -----
`default_nettype none
interface oaht_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  action;
	logic [63:0] key;
	logic signed [31:0] value;
	modport source (output valid, action, key, value, input ready);
	modport sink   (input valid, action, key, value, output ready);
endinterface

interface oaht_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic signed [31:0] value_out;
	logic [6:0]  probes_used;
	logic [6:0]  live_count;
	modport source (output valid, status, value_out, probes_used, live_count, input ready);
	modport sink   (input valid, status, value_out, probes_used, live_count, output ready);
endinterface
`default_nettype wire

// ----- design/open_addressing_hash_table.sv -----
`default_nettype none
// From accept to result valid: the key is hashed byte by byte, both hashes are reduced,
// then slots are probed, each read and then evaluated, until the scan ends or is exhausted;
// the result is then loaded. A clear runs the clearing pass; an unused action skips both.
// One item at a time: the next item can be accepted in the cycle after the result is loaded.
// Reset (arst_n, async) runs a clearing pass marking all slots empty;
// no item is accepted during it. Config resets to linear probing, capacity 8.
module open_addressing_hash_table #(
	parameter int CAPACITY  = oaht_pkg::CAPACITY_DEF,
	parameter int KEY_BYTES = oaht_pkg::KEY_BYTES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	oaht_in_if.sink                          in_ch,
	oaht_out_if.source                       out_ch,
	input  wire logic                        cfg_we,
	input  wire logic [oaht_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [oaht_pkg::CFG_W-1:0]  cfg_data
);
	import oaht_pkg::*;

	oaht_cmd_t   cmd;
	oaht_sts_t   sts;
	logic        res_load, ovalid_q;
	logic [2:0]  r_status;
	logic [31:0] r_value;
	logic [6:0]  r_probes, r_count;

	oaht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.res_free(!ovalid_q || out_ch.ready), .sts(sts), .cmd(cmd), .res_load(res_load)
	);

	oaht_dp #(.CAPACITY(CAPACITY), .KEY_BYTES(KEY_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .action(in_ch.action), .key(in_ch.key),
		.value(in_ch.value), .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .r_status(r_status), .r_value(r_value),
		.r_probes(r_probes), .r_count(r_count)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (res_load) ovalid_q <= 1'b1;
		else if (out_ch.ready) ovalid_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_ch.status      <= r_status;
			out_ch.value_out   <= r_value;
			out_ch.probes_used <= r_probes;
			out_ch.live_count  <= r_count;
		end
	end
	assign out_ch.valid = ovalid_q;
endmodule
`default_nettype wire

// ----- design/oaht_ctrl.sv -----
`default_nettype none
module oaht_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               res_free,
	input  wire oaht_pkg::oaht_sts_t sts,
	output oaht_pkg::oaht_cmd_t     cmd,
	output logic                    res_load
);
	import oaht_pkg::*;

	typedef enum logic [7:0] {
		S_INIT  = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_HASH  = 8'b0000_0100,
		S_MOD   = 8'b0000_1000,
		S_RD    = 8'b0001_0000,
		S_ACT   = 8'b0010_0000,
		S_WAIT  = 8'b0100_0000,
		S_CLR   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// Next-state and command decode.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		res_load = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.act_clear) begin
					cmd.clr_start = 1'b1;
					state_d = S_CLR;
				end else if (sts.act_bad) begin
					state_d = S_WAIT;
				end else if (sts.hash_done) begin
					cmd.mod_start = 1'b1;
					state_d = S_MOD;
				end else begin
					cmd.hash_step = 1'b1;
				end
			end
			S_MOD: begin
				if (sts.mod_done) begin
					cmd.probe_init = 1'b1;
					state_d = S_RD;
				end else begin
					cmd.mod_step = 1'b1;
				end
			end
			S_RD: begin
				if (sts.scan_last) begin
					cmd.fin_full = 1'b1;
					state_d = S_WAIT;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_ACT;
				end
			end
			S_ACT: begin
				cmd.act = 1'b1;
				if (sts.hit_done) state_d = S_WAIT;
				else begin
					cmd.next = 1'b1;
					state_d = S_RD;
				end
			end
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_done) begin
					cmd.fin_imm = 1'b1;
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
		if (state_q == S_HASH && sts.act_bad) cmd.fin_imm = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else         state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_one_hot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("controller state not one-hot");
	a_res_only_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> state_q == S_WAIT)
		else $error("result loaded outside wait state");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_HASH)
		else $error("accepted item did not start hashing");
`endif
endmodule
`default_nettype wire

// ----- design/oaht_dp.sv -----
`default_nettype none
module oaht_dp #(
	parameter int CAPACITY  = oaht_pkg::CAPACITY_DEF,
	parameter int KEY_BYTES = oaht_pkg::KEY_BYTES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [2:0]                 action,
	input  wire logic [63:0]                key,
	input  wire logic [31:0]                value,
	input  wire logic                       cfg_we,
	input  wire logic [oaht_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [oaht_pkg::CFG_W-1:0] cfg_data,
	input  wire oaht_pkg::oaht_cmd_t        cmd,
	output oaht_pkg::oaht_sts_t             sts,
	output logic [2:0]                      r_status,
	output logic [31:0]                     r_value,
	output logic [6:0]                      r_probes,
	output logic [6:0]                      r_count
);
	import oaht_pkg::*;

	localparam int IW = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int BW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES + 1) : 1;
	localparam int RW = CW + 1;

	// Configuration registers.
	logic [1:0]       probe_mode_q;
	logic [CFG_W-1:0] cap_reg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_mode_q <= PM_LINEAR;
			cap_reg_q    <= CFG_W'(8);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_PROBE_MODE: probe_mode_q <= cfg_data[1:0];
				REG_CAPACITY:   cap_reg_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective capacity, clamped.
	logic [CW-1:0] cap;
	always_comb begin
		if (cap_reg_q < CFG_W'(2)) cap = CW'(2);
		else if ({{(32-CFG_W){1'b0}}, cap_reg_q} > 32'(CAPACITY)) cap = CW'(CAPACITY);
		else cap = CW'(cap_reg_q);
	end

	// Item registers and byte-serial hashing.
	logic [2:0]  act_q;
	logic [63:0] kshift_q, nkey_q;
	logic [31:0] val_q;
	logic [63:0] h1_q, h2_q;
	logic [BW-1:0] bcnt_q;
	logic          hdone_q;
	logic [7:0]    cur_byte;
	assign cur_byte = kshift_q[7:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q    <= action;
			kshift_q <= key;
			nkey_q   <= '0;
			val_q    <= value;
			h1_q     <= 64'd5381;
			h2_q     <= '0;
			bcnt_q   <= '0;
			hdone_q  <= 1'b0;
		end else if (cmd.hash_step) begin
			if (cur_byte == 8'd0 || bcnt_q == BW'(KEY_BYTES)) begin
				hdone_q <= 1'b1;
			end else begin
				h1_q     <= (h1_q << 5) + h1_q + {56'd0, cur_byte};
				h2_q     <= (h2_q << 5) - h2_q + {56'd0, cur_byte};
				nkey_q   <= nkey_q | ({56'd0, cur_byte} << {bcnt_q, 3'b000});
				kshift_q <= kshift_q >> 8;
				bcnt_q   <= bcnt_q + BW'(1);
			end
		end
	end

	// Restoring reduction of both hashes, one bit a step.
	logic [63:0]   m1_q, m2_q;
	logic [RW-1:0] r1_q, r2_q;
	logic [6:0]    mcnt_q;
	logic [RW-1:0] t1, t2;
	logic [CW-1:0] capm1;
	assign capm1 = cap - CW'(1);
	assign t1 = {r1_q[RW-2:0], m1_q[63]};
	assign t2 = {r2_q[RW-2:0], m2_q[63]};

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			m1_q   <= h1_q;
			m2_q   <= h2_q;
			r1_q   <= '0;
			r2_q   <= '0;
			mcnt_q <= '0;
		end else if (cmd.mod_step) begin
			m1_q   <= m1_q << 1;
			m2_q   <= m2_q << 1;
			r1_q   <= (t1 >= RW'(cap))   ? t1 - RW'(cap)   : t1;
			r2_q   <= (t2 >= RW'(capm1)) ? t2 - RW'(capm1) : t2;
			mcnt_q <= mcnt_q + 7'd1;
		end
	end

	// Probe state: index, step and probe count.
	logic [CW-1:0] idx_q, stp_q, pcnt_q, h2s;
	logic [CW:0]   sum_idx, sum_stp;
	assign h2s = CW'(r2_q) + CW'(1);
	always_comb begin
		sum_stp = {1'b0, stp_q} + {1'b0, CW'(2)};
		case (probe_mode_q)
			PM_LINEAR:    sum_idx = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};
			PM_QUADRATIC: sum_idx = {1'b0, idx_q} + {1'b0, stp_q};
			default:      sum_idx = {1'b0, idx_q} + {1'b0, h2s};
		endcase
	end

	// Slot storage: keys, values and slot status in memories; the status
	// memory is emptied by the clearing pass after reset and on a clear.
	logic [63:0] kmem [CAPACITY];
	logic [31:0] vmem [CAPACITY];
	logic [1:0]  stat_q [CAPACITY];
	logic [63:0] rk_q;
	logic [31:0] rv_q;
	logic [1:0]  rs_q;
	logic [CW-1:0] count_q, clr_q;
	logic [IW-1:0] ia;
	assign ia = idx_q[IW-1:0];

	logic hit, do_wkv, do_wv, do_del, end_scan;
	always_comb begin
		hit      = (rs_q == SLOT_OCCUPIED) && (rk_q == nkey_q);
		do_wkv   = 1'b0;
		do_wv    = 1'b0;
		do_del   = 1'b0;
		end_scan = 1'b0;
		if (act_q == ACT_INSERT) begin
			if (hit) begin do_wv = 1'b1; end_scan = 1'b1; end
			else if (rs_q != SLOT_OCCUPIED) begin do_wkv = 1'b1; end_scan = 1'b1; end
		end else begin
			if (rs_q == SLOT_EMPTY) end_scan = 1'b1;
			else if (hit) begin
				end_scan = 1'b1;
				if (act_q == ACT_DELETE) do_del = 1'b1;
				if (act_q == ACT_UPDATE) do_wv = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rk_q <= kmem[ia];
			rv_q <= vmem[ia];
		end
		if (cmd.act && do_wkv) kmem[ia] <= nkey_q;
		if (cmd.act && (do_wkv || do_wv)) vmem[ia] <= val_q;
	end

	// Slot status memory: one read or one write a cycle.
	always_ff @(posedge clk) begin
		if (cmd.rd) rs_q <= stat_q[ia];
		if (cmd.act && do_wkv) stat_q[ia] <= SLOT_OCCUPIED;
		if (cmd.act && do_del) stat_q[ia] <= SLOT_DELETED;
		if (cmd.clr_step) stat_q[clr_q[IW-1:0]] <= SLOT_EMPTY;
	end

	// Live count and clearing pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.act && do_wkv) count_q <= count_q + CW'(1);
			if (cmd.act && do_del) begin
				if (count_q != '0) count_q <= count_q - CW'(1);
			end
			if (cmd.clr_start) clr_q <= '0;
			else if (cmd.clr_step) begin
				clr_q   <= clr_q + CW'(1);
				count_q <= '0;
			end
		end
	end

	// Probe index advance and result capture.
	always_ff @(posedge clk) begin
		if (cmd.probe_init) begin
			idx_q  <= CW'(r1_q);
			stp_q  <= CW'(1);
			pcnt_q <= '0;
		end else if (cmd.next) begin
			idx_q  <= (sum_idx >= {1'b0, cap}) ? CW'(sum_idx - {1'b0, cap}) : CW'(sum_idx);
			stp_q  <= (sum_stp >= {1'b0, cap}) ? CW'(sum_stp - {1'b0, cap}) : CW'(sum_stp);
			pcnt_q <= pcnt_q + CW'(1);
		end
		if (cmd.act && end_scan) begin
			r_probes <= 7'(pcnt_q + CW'(1));
			if (act_q == ACT_INSERT) begin
				r_status <= hit ? ST_OVERWRITTEN : ST_INSERTED;
				r_value  <= val_q;
			end else if (rs_q == SLOT_EMPTY) begin
				r_status <= ST_NOT_FOUND;
				r_value  <= '1;
			end else if (act_q == ACT_SEARCH) begin
				r_status <= ST_FOUND;
				r_value  <= rv_q;
			end else if (act_q == ACT_DELETE) begin
				r_status <= ST_DELETED_RES;
				r_value  <= rv_q;
			end else begin
				r_status <= ST_FOUND;
				r_value  <= val_q;
			end
		end
		if (cmd.fin_full) begin
			r_status <= (act_q == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
			r_value  <= '1;
			r_probes <= 7'(cap);
		end
		if (cmd.fin_imm) begin
			r_status <= (act_q == ACT_CLEAR) ? ST_CLEARED : ST_NOT_FOUND;
			r_value  <= '1;
			r_probes <= '0;
		end
	end
	assign r_count = 7'(count_q);

	// Status back to the controller.
	always_comb begin
		sts.hash_done = hdone_q;
		sts.mod_done  = (mcnt_q == 7'd64);
		sts.hit_done  = end_scan;
		sts.scan_last = ({1'b0, pcnt_q} + {{CW{1'b0}}, 1'b1} > {1'b0, cap}) ||
		                (pcnt_q == cap);
		sts.clr_done  = (clr_q == CW'(CAPACITY - 1));
		sts.act_clear = (act_q == ACT_CLEAR);
		sts.act_bad   = (act_q > ACT_CLEAR);
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("live count above capacity");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> idx_q < cap)
		else $error("probe index out of range");
	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.act |-> !(do_wkv && do_del))
		else $error("insert and delete in one step");
`endif
endmodule
`default_nettype wire
